@@ rtl/rmbd_pkg.sv @@
package rmbd_pkg;

   // Image and binning geometry.
   localparam int BIN_SIZE     = 5;
   localparam int IMAGE_WIDTH  = 320;
   localparam int IMAGE_HEIGHT = 240;
   localparam int BIN_COLS     = IMAGE_WIDTH / BIN_SIZE;
   localparam int BIN_ROWS     = IMAGE_HEIGHT / BIN_SIZE;
   localparam int BIN_COUNT    = BIN_COLS * BIN_ROWS;
   localparam int BIN_AREA     = BIN_SIZE * BIN_SIZE;
   localparam int ADDR_W       = $clog2(BIN_COUNT);

   // Field widths.
   localparam int BIN_W   = 13;
   localparam int PIX_W   = 8;
   localparam int GRAY_W  = 8;
   localparam int COORD_W = 9;
   localparam int RATIO_W = 6;

   // Divider sizing: numerator is bin*255, denominator is BIN_AREA*peak.
   localparam int NUM_W   = BIN_W + GRAY_W;
   localparam int DEN_W   = PIX_W + $clog2(BIN_AREA + 1);
   localparam int DIV_W   = ((NUM_W > DEN_W + GRAY_W) ? NUM_W : DEN_W + GRAY_W) + 1;
   localparam int BITIDX_W = $clog2(GRAY_W);

   // Reciprocal used to divide a coordinate by the bin size.
   localparam int RECIP_SHIFT = COORD_W;
   localparam int RECIP       = (1 << RECIP_SHIFT) / BIN_SIZE;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   // Register reset values.
   localparam logic [RATIO_W-1:0] RATIO_RESET  = RATIO_W'(12);
   localparam logic [PIX_W-1:0]   OFFSET_RESET = PIX_W'(10);

   // Configuration register indexes.
   localparam logic CSR_RATIO  = 1'b0;
   localparam logic CSR_OFFSET = 1'b1;

   // Request codes.
   localparam logic [1:0] REQ_ACCUM = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [COORD_W-1:0] pix_x;
      logic [7:0]         pix_y;
      logic [PIX_W-1:0]   red;
      logic [PIX_W-1:0]   green;
      logic [PIX_W-1:0]   blue;
      logic [5:0]         bin_x;
      logic [5:0]         bin_y;
   } req_payload_type;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic [PIX_W-1:0]  peak_red;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                req_load;
      logic                clr_start;
      logic                clr_write;
      logic                rd_bin;
      logic                pix_write;
      logic                div_init;
      logic                div_step;
      logic [BITIDX_W-1:0] div_bit;
      logic                out_load;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic pix_hit;
      logic out_full;
   } dp_status_type;

   // Quotient of a coordinate by the bin size, by reciprocal and one correction.
   function automatic logic [COORD_W-1:0] bin_div(input logic [COORD_W-1:0] x);
      logic [COORD_W+RECIP_W-1:0] prod;
      logic [COORD_W-1:0]         q;
      logic [COORD_W+4:0]         back;
      logic [COORD_W+4:0]         rem;
      prod = (COORD_W + RECIP_W)'(x) * (COORD_W + RECIP_W)'(RECIP);
      q    = COORD_W'(prod >> RECIP_SHIFT);
      back = (COORD_W + 5)'(q) * (COORD_W + 5)'(BIN_SIZE);
      rem  = (COORD_W + 5)'(x) - back;
      if (rem >= (COORD_W + 5)'(BIN_SIZE)) begin
         q = q + COORD_W'(1);
      end
      return q;
   endfunction

endpackage

@@ rtl/rmbd_ifs.sv @@
// Request channel.
interface rmbd_req_if import rmbd_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// Result channel.
interface rmbd_rsp_if import rmbd_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/rmbd_ram.sv @@
module rmbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rmbd_datapath.sv @@
module rmbd_datapath import rmbd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ctl_cmd_type     cmd,
   output dp_status_type   status,
   input  req_payload_type req_payload,
   input  logic            csr_wr_en,
   input  logic            csr_index,
   input  logic [PIX_W-1:0] csr_wdata,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   req_payload_type     req_ff;
   logic [RATIO_W-1:0]  ratio_ff;
   logic [PIX_W-1:0]    offset_ff;
   logic [PIX_W-1:0]    peak_ff;
   logic [ADDR_W-1:0]   clr_cnt_ff;
   logic [DIV_W-1:0]    rem_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [GRAY_W-1:0]   quo_ff;
   logic                sat_ff;
   logic                out_full_ff;
   rsp_payload_type     out_ff;

   logic [COORD_W-1:0]  cell_x;
   logic [COORD_W-1:0]  cell_y;
   logic                pix_in_area;
   logic                pix_red;
   logic [ADDR_W-1:0]   pix_addr;
   logic [ADDR_W-1:0]   bin_addr;
   logic                bin_in_area;
   logic [15:0]         lhs;
   logic [15:0]         margin;
   logic [15:0]         rhs_blue;
   logic [15:0]         rhs_green;
   logic [BIN_W:0]      sum;
   logic [BIN_W-1:0]    sum_sat;
   logic [NUM_W-1:0]    num;
   logic [DEN_W-1:0]    den;
   logic [DIV_W-1:0]    trial;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [BIN_W-1:0]    ram_wdata;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [BIN_W-1:0]    ram_rdata;

   // Bin position of the held pixel and of the held read request.
   always_comb begin
      cell_x      = bin_div(req_ff.pix_x);
      cell_y      = bin_div(COORD_W'(req_ff.pix_y));
      pix_in_area = (cell_x < COORD_W'(BIN_COLS)) && (cell_y < COORD_W'(BIN_ROWS));
      pix_addr    = ADDR_W'(cell_y * BIN_COLS + cell_x);
      bin_in_area = (32'(req_ff.bin_x) < BIN_COLS) && (32'(req_ff.bin_y) < BIN_ROWS);
      bin_addr    = ADDR_W'(req_ff.bin_y * BIN_COLS + req_ff.bin_x);
   end

   // Red test: ten times red beats both scaled channels plus the margin.
   always_comb begin
      lhs       = 16'(req_ff.red) * 16'd10;
      margin    = 16'(offset_ff) * 16'd10;
      rhs_blue  = 16'(ratio_ff) * 16'(req_ff.blue) + margin;
      rhs_green = 16'(ratio_ff) * 16'(req_ff.green) + margin;
      pix_red   = (lhs > rhs_blue) && (lhs > rhs_green);
   end

   // Saturating bin update.
   always_comb begin
      sum     = (BIN_W + 1)'(ram_rdata) + (BIN_W + 1)'(req_ff.red);
      sum_sat = sum[BIN_W] ? {BIN_W{1'b1}} : sum[BIN_W-1:0];
   end

   // Bin memory port control.
   always_comb begin
      ram_we    = cmd.clr_write | cmd.pix_write;
      ram_waddr = cmd.clr_write ? clr_cnt_ff : pix_addr;
      ram_wdata = cmd.clr_write ? '0 : sum_sat;
      ram_raddr = cmd.rd_bin ? bin_addr : pix_addr;
   end

   rmbd_ram #(
      .WIDTH (BIN_W),
      .DEPTH (BIN_COUNT)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Divider operands: bin*255 over BIN_AREA*peak, and the trial subtrahend.
   always_comb begin
      num   = (NUM_W'(ram_rdata) << GRAY_W) - NUM_W'(ram_rdata);
      den   = DEN_W'(peak_ff * BIN_AREA);
      trial = DIV_W'(den_ff) << cmd.div_bit;
   end

   // Request hold and configuration registers.
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_payload;
      end
      if (reset) begin
         ratio_ff  <= RATIO_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_RATIO) begin
            ratio_ff <= csr_wdata[RATIO_W-1:0];
         end else begin
            offset_ff <= csr_wdata;
         end
      end
   end

   // Peak value and clearing sweep counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff    <= PIX_W'(1);
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.clr_start) begin
            peak_ff    <= PIX_W'(1);
            clr_cnt_ff <= '0;
         end else if (cmd.clr_write) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
         if (cmd.pix_write && (req_ff.red > peak_ff)) begin
            peak_ff <= req_ff.red;
         end
      end
   end

   // Restoring divider, one quotient bit per step; large quotients saturate.
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= bin_in_area ? DIV_W'(num) : '0;
         den_ff <= den;
         quo_ff <= '0;
         sat_ff <= bin_in_area && (DIV_W'(num) >= (DIV_W'(den) << GRAY_W));
      end else if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_ff              <= rem_ff - trial;
            quo_ff[cmd.div_bit] <= 1'b1;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_full_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_full_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_ff.gray     <= sat_ff ? {GRAY_W{1'b1}} : quo_ff;
         out_ff.peak_red <= peak_ff;
      end
   end

   assign status.clr_last = (clr_cnt_ff == ADDR_W'(BIN_COUNT - 1));
   assign status.pix_hit  = pix_in_area && pix_red;
   assign status.out_full = out_full_ff;
   assign rsp_valid       = out_full_ff;
   assign rsp_payload     = out_ff;

endmodule

@@ rtl/rmbd_ctrl.sv @@
module rmbd_ctrl import rmbd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_type,
   output logic          req_ready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_BIN_RD,
      ST_DIV_INIT,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [BITIDX_W-1:0] bit_ff;
   logic [BITIDX_W-1:0] bit_in;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      bit_in      = bit_ff;
      cmd         = '0;
      cmd.div_bit = bit_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               unique case (req_type)
                  REQ_ACCUM: state_in = ST_PIX_RD;
                  REQ_READ:  state_in = ST_BIN_RD;
                  REQ_CLEAR: begin
                     cmd.clr_start = 1'b1;
                     state_in      = ST_CLEAR;
                  end
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PIX_RD: begin
            state_in = status.pix_hit ? ST_PIX_WR : ST_IDLE;
         end
         ST_PIX_WR: begin
            cmd.pix_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_BIN_RD: begin
            cmd.rd_bin = 1'b1;
            state_in   = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            bit_in       = BITIDX_W'(GRAY_W - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               bit_in = bit_ff - BITIDX_W'(1);
            end
         end
         ST_OUT: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register; reset starts the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
      end
   end

endmodule

@@ rtl/red_mask_bin_downscale.sv @@
// Accumulate: each accepted pixel reads its bin, then writes it back only if it counts.
// Read: bin read, 8-step divider, then output load, which waits while a result is held.
// Clear: one bin zeroed per cycle until the last bin; no request is taken meanwhile.
// A request is taken only in idle, so one item is in flight at a time.
// Synchronous active-high reset runs the same clearing sweep, sets the peak to one
// and the registers to ratio 12 and offset 10.
module red_mask_bin_downscale import rmbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   rmbd_req_if.sink         req_bus,
   rmbd_rsp_if.source       rsp_bus,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [PIX_W-1:0] csr_wdata
);

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          req_ready;

   // Sequencer.
   rmbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.payload.req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Bins, peak, divider and output register.
   rmbd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_bus.payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_payload (rsp_bus.payload)
   );

   assign req_bus.ready = req_ready;

endmodule
